// ===== rtl/rsc_pkg.sv =====
// Shared types, codes and the saturation helper for the RPN stack calculator.
// No dependencies; used by every other file in rtl/.
package rsc_pkg;

  // Item codes carried on the mode field.
  localparam logic [2:0] ModePush    = 3'd0;
  localparam logic [2:0] ModeAdd     = 3'd1;
  localparam logic [2:0] ModeSub     = 3'd2;
  localparam logic [2:0] ModeMul     = 3'd3;
  localparam logic [2:0] ModeDiv     = 3'd4;
  localparam logic [2:0] ModeRem     = 3'd5;
  localparam logic [2:0] ModeEnd     = 3'd6;
  localparam logic [2:0] ModeUnknown = 3'd7;

  // Status codes.
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StEmpty    = 3'd2;
  localparam logic [2:0] StDivZero  = 3'd3;
  localparam logic [2:0] StModZero  = 3'd4;
  localparam logic [2:0] StUnknown  = 3'd5;
  localparam logic [2:0] StInvalid  = 3'd6;
  localparam logic [2:0] StOverflow = 3'd7;

  // Divider geometry: a Q16.16 dividend scaled by 2^16 needs 48 magnitude bits.
  localparam int unsigned DivNumW = 48;
  localparam int unsigned DivCntW = 6;

  typedef struct packed {
    logic       cap;
    logic       rd;
    logic       push;
    logic       set_err;
    logic [2:0] err_code;
    logic       mul_go;
    logic       div_go;
    logic       commit;
    logic       fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       err_set;
    logic       sp_one;
    logic       sp_lt2;
    logic       full;
    logic       top_zero;
    logic       div_done;
  } dp_status_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  // Clamp a wide signed value into 32 bits, flagging when clamping occurred.
  function automatic sat_t sat32(input logic signed [48:0] v);
    sat_t r;
    if (v > 49'sh0_0000_7FFF_FFFF) begin
      r.ovf = 1'b1;
      r.val = 32'h7FFF_FFFF;
    end else if (v < -49'sh0_0000_8000_0000) begin
      r.ovf = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/rsc_div.sv =====
// Restoring radix-2 divider on unsigned magnitudes, one quotient bit per cycle.
// Depends on rsc_pkg for its widths.
module rsc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rsc_pkg::DivNumW-1:0] num_i,
  input  logic [31:0]                 den_i,
  output logic                        done_o,
  output logic [rsc_pkg::DivNumW-1:0] quo_o,
  output logic [31:0]                 rem_o
);

  logic [rsc_pkg::DivNumW-1:0] num_q;
  logic [31:0]                 den_q, rem_q;
  logic [rsc_pkg::DivCntW-1:0] cnt_q;
  logic                        run_q, done_q;
  logic [32:0]                 trial;

  // The partial remainder stays below the divisor, so 33 bits hold the shift.
  assign trial = {rem_q, num_q[rsc_pkg::DivNumW-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= rsc_pkg::DivCntW'(rsc_pkg::DivNumW);
      end else if (run_q) begin
        cnt_q <= cnt_q - rsc_pkg::DivCntW'(1);
        if (cnt_q == rsc_pkg::DivCntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
      end else begin
        rem_q <= {rem_q[30:0], num_q[rsc_pkg::DivNumW-1]};
      end
      num_q <= {num_q[rsc_pkg::DivNumW-2:0], ~trial[32]};
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/rsc_ctrl.sv =====
// Sequencing state machine: decides what each item does and steps the datapath.
// Depends on rsc_pkg for codes and the command and status structs.
module rsc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  rsc_pkg::dp_status_t    stat_i,
  output rsc_pkg::ctrl_cmd_t     cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);

  typedef enum logic [2:0] {
    Idle, Read, Exec, MulCommit, DivWait, Fin
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      Idle: begin
        if (start_i) begin
          cmd_o.cap = 1'b1;
          state_d   = Read;
        end
      end
      Read: begin
        cmd_o.rd = 1'b1;
        state_d  = Exec;
      end
      Exec: begin
        state_d = Fin;
        if (stat_i.mode != rsc_pkg::ModeEnd && !stat_i.err_set) begin
          case (stat_i.mode)
            rsc_pkg::ModePush: begin
              if (stat_i.full) begin
                cmd_o.set_err  = 1'b1;
                cmd_o.err_code = rsc_pkg::StFull;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            rsc_pkg::ModeUnknown: begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = rsc_pkg::StUnknown;
            end
            default: begin
              if (stat_i.mode == rsc_pkg::ModeDiv && stat_i.sp_one && stat_i.top_zero) begin
                cmd_o.set_err  = 1'b1;
                cmd_o.err_code = rsc_pkg::StDivZero;
              end else if (stat_i.sp_lt2) begin
                cmd_o.set_err  = 1'b1;
                cmd_o.err_code = rsc_pkg::StEmpty;
              end else if (stat_i.top_zero && stat_i.mode == rsc_pkg::ModeDiv) begin
                cmd_o.set_err  = 1'b1;
                cmd_o.err_code = rsc_pkg::StDivZero;
              end else if (stat_i.top_zero && stat_i.mode == rsc_pkg::ModeRem) begin
                cmd_o.set_err  = 1'b1;
                cmd_o.err_code = rsc_pkg::StModZero;
              end else begin
                case (stat_i.mode) inside
                  rsc_pkg::ModeAdd, rsc_pkg::ModeSub: cmd_o.commit = 1'b1;
                  rsc_pkg::ModeMul: begin
                    cmd_o.mul_go = 1'b1;
                    state_d      = MulCommit;
                  end
                  default: begin
                    cmd_o.div_go = 1'b1;
                    state_d      = DivWait;
                  end
                endcase
              end
            end
          endcase
        end
      end
      MulCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = Fin;
      end
      DivWait: begin
        if (stat_i.div_done) begin
          cmd_o.commit = 1'b1;
          state_d      = Fin;
        end
      end
      Fin: begin
        cmd_o.fin = 1'b1;
        state_d   = Idle;
      end
      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == Fin);
    end
  end

  assign busy_o = (state_q != Idle);
  assign done_o = done_q;

endmodule

// ===== rtl/rsc_datapath.sv =====
// Operand stack, sticky error, arithmetic units and result registers.
// Depends on rsc_pkg and instantiates rsc_div.
module rsc_datapath #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsc_pkg::ctrl_cmd_t  cmd_i,
  input  logic [2:0]          mode_i,
  input  logic signed [31:0]  operand_value_i,
  output rsc_pkg::dp_status_t stat_o,
  output logic [2:0]          status_o,
  output logic signed [31:0]  top_value_o,
  output logic [7:0]          stack_depth_o,
  output logic                expression_done_o
);

  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  // The top entry lives in top_q; the memory holds the entries beneath it.
  logic [31:0]        mem [STACK_DEPTH];
  logic [SPW-1:0]     sp_q;
  logic [2:0]         err_q;
  logic [31:0]        top_q, rd_q, val_q;
  logic [2:0]         mode_q;
  logic signed [63:0] prod_q;

  logic [2:0]  out_status_q;
  logic [31:0] out_top_q;
  logic [7:0]  out_depth_q;
  logic        out_end_q;

  logic signed [31:0] a_s, b_s;
  logic [31:0]        a_mag, b_mag;
  logic signed [32:0] addsub;
  logic signed [47:0] mul_shift;
  logic signed [48:0] wide;
  logic               div_done;
  logic [rsc_pkg::DivNumW-1:0] div_num, div_quo;
  logic [31:0]        div_rem;
  logic [31:0]        rem_val;
  rsc_pkg::sat_t      sat;
  logic               res_ovf;
  logic [31:0]        res_val;

  assign a_s   = rd_q;
  assign b_s   = top_q;
  assign a_mag = a_s[31] ? 32'(-a_s) : a_s;
  assign b_mag = b_s[31] ? 32'(-b_s) : b_s;

  assign div_num = (mode_q == rsc_pkg::ModeDiv) ? {a_mag, 16'h0000}
                                                 : rsc_pkg::DivNumW'(a_mag);

  rsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (div_num),
    .den_i   (b_mag),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign addsub    = (mode_q == rsc_pkg::ModeSub) ? (33'(a_s) - 33'(b_s))
                                                  : (33'(a_s) + 33'(b_s));
  // Arithmetic shift rounds down; add one for a negative product with a fraction.
  assign mul_shift = prod_q[63:16] + 48'(prod_q[63] && (prod_q[15:0] != 16'h0000));
  assign rem_val   = a_s[31] ? 32'(-div_rem) : div_rem;

  always_comb begin
    case (mode_q)
      rsc_pkg::ModeMul: wide = 49'(mul_shift);
      rsc_pkg::ModeDiv: wide = (a_s[31] ^ b_s[31]) ? -$signed({1'b0, div_quo})
                                                   : $signed({1'b0, div_quo});
      default:          wide = 49'(addsub);
    endcase
    sat = rsc_pkg::sat32(wide);
    if (mode_q == rsc_pkg::ModeRem) begin
      res_ovf = 1'b0;
      res_val = rem_val;
    end else begin
      res_ovf = sat.ovf;
      res_val = sat.val;
    end
  end

  always_comb begin
    stat_o.mode     = mode_q;
    stat_o.err_set  = (err_q != rsc_pkg::StOk);
    stat_o.sp_one   = (sp_q == SPW'(1));
    stat_o.sp_lt2   = (sp_q < SPW'(2));
    stat_o.full     = (sp_q == SPW'(STACK_DEPTH));
    stat_o.top_zero = (top_q == 32'h0000_0000);
    stat_o.div_done = div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q      <= '0;
      err_q     <= rsc_pkg::StOk;
      out_end_q <= 1'b0;
    end else begin
      if (cmd_i.set_err) begin
        err_q <= cmd_i.err_code;
      end
      if (cmd_i.push) begin
        sp_q <= sp_q + SPW'(1);
      end
      if (cmd_i.commit) begin
        sp_q <= sp_q - SPW'(1);
        if (res_ovf) begin
          err_q <= rsc_pkg::StOverflow;
        end
      end
      if (cmd_i.fin) begin
        out_end_q <= (mode_q == rsc_pkg::ModeEnd);
        if (mode_q == rsc_pkg::ModeEnd) begin
          sp_q  <= '0;
          err_q <= rsc_pkg::StOk;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      mode_q <= mode_i;
      val_q  <= operand_value_i;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[AW'(sp_q - SPW'(2))];
    end
    if (cmd_i.push) begin
      if (sp_q != '0) begin
        mem[AW'(sp_q - SPW'(1))] <= top_q;
      end
      top_q <= val_q;
    end
    if (cmd_i.mul_go) begin
      prod_q <= a_s * b_s;
    end
    if (cmd_i.commit) begin
      top_q <= res_val;
    end
    if (cmd_i.fin) begin
      if (mode_q == rsc_pkg::ModeEnd) begin
        out_depth_q <= 8'h00;
        if (err_q != rsc_pkg::StOk) begin
          out_status_q <= err_q;
          out_top_q    <= 32'h0000_0000;
        end else if (sp_q == SPW'(1)) begin
          out_status_q <= rsc_pkg::StOk;
          out_top_q    <= top_q;
        end else begin
          out_status_q <= rsc_pkg::StInvalid;
          out_top_q    <= 32'h0000_0000;
        end
      end else begin
        out_status_q <= err_q;
        out_top_q    <= (sp_q != '0) ? top_q : 32'h0000_0000;
        out_depth_q  <= 8'(sp_q);
      end
    end
  end

  assign status_o          = out_status_q;
  assign top_value_o       = out_top_q;
  assign stack_depth_o     = out_depth_q;
  assign expression_done_o = out_end_q;

endmodule

// ===== rtl/rpn_stack_calculator_core.sv =====
// Top level of the reverse Polish stack calculator core.
// Depends on rsc_pkg; instantiates rsc_ctrl and rsc_datapath.
//
//   Channel   Handshake             Ports
//   --------  --------------------  ---------------------------------------------
//   item in   start & !busy         mode_i, operand_value_i
//   result    done_o (one cycle)    status_o, top_value_o, stack_depth_o,
//                                   expression_done_o
//
// Each item is handled on its own. A push, end, unknown code, rejected
// operator, add or subtract passes through the Read, Exec and Fin states;
// a multiply adds MulCommit for the registered 32x32 multiplier; a divide
// or remainder waits in DivWait on the 48-step restoring divider. busy is
// low again in the cycle in which done_o is high, so the next item may be
// accepted while the previous result is presented. The receiver cannot
// stall: each result is shown for exactly one cycle. Reset empties the
// stack and clears the error; the stack memory itself is not cleared,
// since only entries below the stack pointer are ever read.
module rpn_stack_calculator_core #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode_i,
  input  logic signed [31:0] operand_value_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] top_value_o,
  output logic [7:0]         stack_depth_o,
  output logic               expression_done_o
);

  // The controller sees only the datapath's status flags and drives it
  // purely through the command struct.
  rsc_pkg::ctrl_cmd_t  cmd;
  rsc_pkg::dp_status_t stat;

  rsc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  rsc_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .mode_i            (mode_i),
    .operand_value_i   (operand_value_i),
    .stat_o            (stat),
    .status_o          (status_o),
    .top_value_o       (top_value_o),
    .stack_depth_o     (stack_depth_o),
    .expression_done_o (expression_done_o)
  );

endmodule
